FILE: rtl/core/jdef_pkg.sv
// Shared constants, types and helpers for the joint double exponential filter.
// No dependencies; every other file of the block imports this package.
package jdef_pkg;

    localparam int NUM_JOINTS = 25;
    localparam int IDX_W      = 5;
    localparam int POS_W      = 32;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREDICTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXDEV     = 3'd4;

    localparam logic [16:0] RST_SMOOTHING  = 17'd16384;
    localparam logic [16:0] RST_CORRECTION = 17'd16384;
    localparam logic [18:0] RST_PREDICTION = 19'd16384;
    localparam logic [20:0] RST_JITTER     = 21'd1966;
    localparam logic [20:0] RST_MAXDEV     = 21'd3277;
    localparam logic [16:0] WGT_ONE        = 17'd65536;
    localparam logic [20:0] JITTER_MIN     = 21'd7;

    // Datapath widths
    localparam int MUL_AW = 36;  // signed operand of the weight multiplier
    localparam int MUL_WW = 19;  // unsigned Q3.16 weight
    localparam int MUL_RW = 39;  // signed floor(a * w / 2^16)
    localparam int VL_CW  = 33;  // signed vector component
    localparam int VL_LW  = 34;  // vector length
    localparam int DIV_NW = 38;  // ratio numerator
    localparam int DIV_DW = 34;  // ratio denominator
    localparam int DIV_QW = 17;  // ratio, at most 1.0 in Q1.16

    typedef struct packed {
        logic [2:0][POS_W-1:0] raw;
        logic [2:0][POS_W-1:0] filt;
        logic [2:0][POS_W-1:0] trend;
        logic [1:0]            fc;
    } t_jstate;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [39:0] v);
        logic signed [POS_W-1:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/jdef_mul.sv
// Three-stage weight multiplier: floor(a * w / 65536) for signed a, unsigned w.
// Depends on jdef_pkg; the operand is split into two 18-bit halves.
module jdef_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [jdef_pkg::MUL_AW-1:0]  i_a,
    input  logic        [jdef_pkg::MUL_WW-1:0]  i_w,
    output logic                                o_done,
    output logic signed [jdef_pkg::MUL_RW-1:0]  o_res
);
    import jdef_pkg::*;

    logic [MUL_AW-1:0] r_mag;
    logic [MUL_WW-1:0] r_w;
    logic              r_neg1, r_neg2;
    logic              r_v1, r_v2;
    logic [36:0]       r_plo, r_phi;
    logic [55:0]       sum;
    logic [55:0]       sum_up;

    always_comb begin
        sum    = 56'(r_plo) + (56'(r_phi) << 18);
        sum_up = sum + 56'd65535;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            o_done <= r_v2;
        end
        // magnitude and sign
        r_mag  <= i_a[MUL_AW-1] ? MUL_AW'(-i_a) : MUL_AW'(i_a);
        r_neg1 <= i_a[MUL_AW-1];
        r_w    <= i_w;
        // partial products
        r_plo  <= 37'(r_mag[17:0] * r_w);
        r_phi  <= 37'(r_mag[35:18] * r_w);
        r_neg2 <= r_neg1;
        // round toward minus infinity
        o_res  <= r_neg2 ? -$signed(MUL_RW'(sum_up >> 16)) : $signed(MUL_RW'(sum >> 16));
    end

endmodule

FILE: rtl/core/jdef_vlen.sv
// Vector length unit: floor square root of the sum of squares, three squares
// then one root bit per cycle. Depends on jdef_pkg.
module jdef_vlen (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [jdef_pkg::VL_CW-1:0]  i_a,
    input  logic signed [jdef_pkg::VL_CW-1:0]  i_b,
    input  logic signed [jdef_pkg::VL_CW-1:0]  i_c,
    output logic                               o_done,
    output logic        [jdef_pkg::VL_LW-1:0]  o_len
);
    import jdef_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SQ, ST_RT} t_state;

    t_state             r_state;
    logic [30:0]        r_m [3];
    logic [1:0]         r_s;
    logic [1:0]         r_k;
    logic [63:0]        r_acc;
    logic [63:0]        r_rad;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [4:0]         r_cnt;

    logic [VL_CW-1:0]   ma, mb, mc, mx;
    logic [1:0]         shift;
    logic [61:0]        sq;
    logic [35:0]        rem_sh, trial;
    logic [31:0]        root_nx;
    logic [33:0]        rem_nx;

    always_comb begin
        ma = i_a[VL_CW-1] ? VL_CW'(-i_a) : VL_CW'(i_a);
        mb = i_b[VL_CW-1] ? VL_CW'(-i_b) : VL_CW'(i_b);
        mc = i_c[VL_CW-1] ? VL_CW'(-i_c) : VL_CW'(i_c);
        mx = ma;
        if (mb > mx) begin
            mx = mb;
        end
        if (mc > mx) begin
            mx = mc;
        end
        if (mx[32]) begin
            shift = 2'd2;
        end else if (mx[31]) begin
            shift = 2'd1;
        end else begin
            shift = 2'd0;
        end
        sq     = 62'(r_m[r_k] * r_m[r_k]);
        rem_sh = {r_rem, r_rad[63:62]};
        trial  = {2'b00, r_root, 2'b01};
        if (rem_sh >= trial) begin
            rem_nx  = 34'(rem_sh - trial);
            root_nx = {r_root[30:0], 1'b1};
        end else begin
            rem_nx  = 34'(rem_sh);
            root_nx = {r_root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_m[0]  <= 31'(ma >> shift);
                        r_m[1]  <= 31'(mb >> shift);
                        r_m[2]  <= 31'(mc >> shift);
                        r_s     <= shift;
                        r_k     <= 2'd0;
                        r_acc   <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_acc <= r_acc + 64'(sq);
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_rad   <= r_acc + 64'(sq);
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_RT;
                    end
                end
                ST_RT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= rem_nx;
                    r_root <= root_nx;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        o_len   <= VL_LW'(root_nx) << r_s;
                        o_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/jdef_div.sv
// Ratio divider: floor(num / den) for a quotient known to fit 17 bits,
// one restoring step per cycle. Depends on jdef_pkg.
module jdef_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [jdef_pkg::DIV_NW-1:0]        i_num,
    input  logic [jdef_pkg::DIV_DW-1:0]        i_den,
    output logic                               o_done,
    output logic [jdef_pkg::DIV_QW-1:0]        o_q
);
    import jdef_pkg::*;

    localparam int SH_W = DIV_DW + DIV_QW - 1;

    logic              r_busy;
    logic [DIV_NW-1:0] r_rem;
    logic [SH_W-1:0]   r_dsh;
    logic [DIV_QW-1:0] r_q;
    logic [4:0]        r_cnt;
    logic              fits;

    assign fits = (SH_W'(r_rem) >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_rem  <= i_num;
                    r_dsh  <= SH_W'(i_den) << (DIV_QW - 1);
                    r_q    <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else begin
                if (fits) begin
                    r_rem <= r_rem - DIV_NW'(r_dsh);
                end
                r_q   <= {r_q[DIV_QW-2:0], fits};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_QW - 1)) begin
                    o_q    <= {r_q[DIV_QW-2:0], fits};
                    o_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: rtl/core/joint_double_exponential_filter.sv
// Joint double exponential filter, top level.
// Work per item: the bit-serial root, the ratio divider and the three-stage multiplier,
// used as the joint's frame count and the jitter and deviation clamps require; an
// output stall holds the finished item until the output register is free.
// One item at a time: the next is accepted only once the result has been registered.
// Synchronous active-low reset restores default weights and clears joint valid bits.
module joint_double_exponential_filter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [jdef_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [jdef_pkg::CFG_DAT_W-1:0]       i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [jdef_pkg::IDX_W-1:0]           i_joint_index,
    input  logic signed [jdef_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [jdef_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [jdef_pkg::POS_W-1:0]    i_pos_z,
    input  logic                                 i_inferred,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [jdef_pkg::IDX_W-1:0]           o_out_index,
    output logic signed [jdef_pkg::POS_W-1:0]    o_out_x,
    output logic signed [jdef_pkg::POS_W-1:0]    o_out_y,
    output logic signed [jdef_pkg::POS_W-1:0]    o_out_z
);
    import jdef_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_SETUP, ST_JGO, ST_JLEN, ST_JDGO, ST_JDIV,
        ST_MUL, ST_MWAIT, ST_DGO, ST_DLEN, ST_DDGO, ST_DDIV, ST_WB
    } t_state;

    // which product the shared multiplier is working on
    typedef enum logic [2:0] {OP_JIT, OP_SMO, OP_TRD, OP_PRD, OP_DEV} t_op;

    localparam logic [1:0] FC_NEW = 2'd0;
    localparam logic [1:0] FC_ONE = 2'd1;
    localparam logic [1:0] FC_RUN = 2'd2;

    // configuration
    logic [16:0] r_smoothing, r_correction;
    logic [18:0] r_prediction;
    logic [20:0] r_jitter, r_maxdev;

    // joint state memory, registered read
    t_jstate               r_mem [NUM_JOINTS];
    logic [NUM_JOINTS-1:0] r_vld;
    t_jstate               r_rd_data;
    logic                  r_rd_vld;
    logic                  mem_we;
    t_jstate               wr_data;

    // item being worked
    t_state                r_state;
    t_op                   r_op;
    logic [1:0]            r_k;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_inf;
    logic signed [31:0]    r_r [3];
    logic signed [31:0]    r_pf [3];
    logic signed [31:0]    r_pt [3];
    logic signed [33:0]    r_f [3];
    logic signed [31:0]    r_t [3];
    logic signed [31:0]    r_p [3];
    logic [1:0]            r_fc;
    logic [16:0]           r_ws, r_wc;
    logic [21:0]           r_rj, r_rm;
    logic [VL_LW-1:0]      r_len;
    logic [DIV_QW-1:0]     r_ratio;

    // arithmetic units
    logic                     mul_start, mul_done;
    logic signed [MUL_AW-1:0] mul_a;
    logic [MUL_WW-1:0]        mul_w;
    logic signed [MUL_RW-1:0] mul_res;
    logic                     vl_start, vl_done;
    logic signed [VL_CW-1:0]  vl_c [3];
    logic [VL_LW-1:0]         vl_len;
    logic                     dv_start, dv_done;
    logic [DIV_NW-1:0]        dv_num;
    logic [DIV_DW-1:0]        dv_den;
    logic [DIV_QW-1:0]        dv_q;

    logic signed [33:0]    base;
    logic signed [39:0]    acc_sum;
    t_jstate               rd;
    logic                  raw_zero;
    logic [1:0]            fc_old;
    logic signed [32:0]    avg_sum [3];
    logic [20:0]           jr_min;
    logic                  out_free;

    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;
    assign mul_start  = (r_state == ST_MUL);
    assign vl_start   = (r_state == ST_JGO) || (r_state == ST_DGO);
    assign dv_start   = (r_state == ST_JDGO) || (r_state == ST_DDGO);
    assign mem_we     = (r_state == ST_WB) && out_free;

    always_comb begin
        // operand of the current component product
        case (r_op)
            OP_JIT: begin
                mul_a = MUL_AW'(r_r[r_k]) - MUL_AW'(r_pf[r_k]);
                mul_w = MUL_WW'(r_ratio);
                base  = 34'(r_pf[r_k]);
            end
            OP_SMO: begin
                mul_a = MUL_AW'(r_pf[r_k]) + MUL_AW'(r_pt[r_k]) - MUL_AW'(r_f[r_k]);
                mul_w = MUL_WW'(r_ws);
                base  = r_f[r_k];
            end
            OP_TRD: begin
                mul_a = MUL_AW'(r_f[r_k]) - MUL_AW'(r_pf[r_k]) - MUL_AW'(r_pt[r_k]);
                mul_w = MUL_WW'(r_wc);
                base  = 34'(r_pt[r_k]);
            end
            OP_PRD: begin
                mul_a = MUL_AW'(r_t[r_k]);
                mul_w = r_prediction;
                base  = r_f[r_k];
            end
            default: begin
                mul_a = MUL_AW'(r_p[r_k]) - MUL_AW'(r_r[r_k]);
                mul_w = MUL_WW'(r_ratio);
                base  = 34'(r_r[r_k]);
            end
        endcase
        acc_sum = 40'(base) + 40'(mul_res);

        // length of the jitter step or of the prediction deviation
        for (int k = 0; k < 3; k++) begin
            if (r_state == ST_DGO) begin
                vl_c[k] = VL_CW'(r_p[k]) - VL_CW'(r_r[k]);
            end else begin
                vl_c[k] = VL_CW'(r_r[k]) - VL_CW'(r_pf[k]);
            end
        end

        if (r_state == ST_DDGO) begin
            dv_num = DIV_NW'(r_rm) << 16;
            dv_den = r_len;
        end else begin
            dv_num = DIV_NW'(r_len) << 16;
            dv_den = DIV_DW'(r_rj);
        end

        // a joint never written reads as zero
        rd       = r_rd_vld ? r_rd_data : '0;
        raw_zero = (r_r[0] == 32'sd0) && (r_r[1] == 32'sd0) && (r_r[2] == 32'sd0);
        fc_old   = raw_zero ? FC_NEW : rd.fc;
        for (int k = 0; k < 3; k++) begin
            avg_sum[k] = 33'(r_r[k]) + 33'($signed(rd.raw[k]));
        end
        jr_min = (r_jitter < JITTER_MIN) ? JITTER_MIN : r_jitter;

        for (int k = 0; k < 3; k++) begin
            wr_data.raw[k]   = r_r[k];
            wr_data.filt[k]  = r_f[k][31:0];
            wr_data.trend[k] = r_t[k];
        end
        wr_data.fc = r_fc;
    end

    jdef_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_w     (mul_w),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    jdef_vlen u_vlen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (vl_start),
        .i_a     (vl_c[0]),
        .i_b     (vl_c[1]),
        .i_c     (vl_c[2]),
        .o_done  (vl_done),
        .o_len   (vl_len)
    );

    jdef_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_q     (dv_q)
    );

    // configuration registers; writes must arrive only while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothing  <= RST_SMOOTHING;
            r_correction <= RST_CORRECTION;
            r_prediction <= RST_PREDICTION;
            r_jitter     <= RST_JITTER;
            r_maxdev     <= RST_MAXDEV;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SMOOTHING:  r_smoothing  <= i_cfg_wdata[16:0];
                CFG_CORRECTION: r_correction <= i_cfg_wdata[16:0];
                CFG_PREDICTION: r_prediction <= i_cfg_wdata[18:0];
                CFG_JITTER:     r_jitter     <= i_cfg_wdata;
                CFG_MAXDEV:     r_maxdev     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // state memory: write back at the end of the item, read the item's joint
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= wr_data;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            r_rd_vld <= r_vld[r_idx];
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_JIT;
            r_k         <= 2'd0;
            o_out_valid <= 1'b0;
        end else begin
            // drop the output item once taken, unless a new one replaces it
            if (o_out_valid && !i_out_stall && (r_state != ST_WB)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_idx <= i_joint_index;
                        r_inf <= i_inferred;
                        r_r[0] <= i_pos_x;
                        r_r[1] <= i_pos_y;
                        r_r[2] <= i_pos_z;
                        // drop an item for a joint that does not exist
                        if (i_joint_index < IDX_W'(NUM_JOINTS)) begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_RD: r_state <= ST_SETUP;
                ST_SETUP: begin
                    r_ws <= (r_smoothing > WGT_ONE) ? WGT_ONE : r_smoothing;
                    r_wc <= (r_correction > WGT_ONE) ? WGT_ONE : r_correction;
                    r_rj <= r_inf ? {jr_min, 1'b0} : {1'b0, jr_min};
                    r_rm <= r_inf ? {r_maxdev, 1'b0} : {1'b0, r_maxdev};
                    r_k  <= 2'd0;
                    for (int k = 0; k < 3; k++) begin
                        r_pf[k] <= $signed(rd.filt[k]);
                        r_pt[k] <= $signed(rd.trend[k]);
                    end
                    case (fc_old)
                        FC_NEW: begin
                            // restart: pass raw through, no trend
                            for (int k = 0; k < 3; k++) begin
                                r_f[k] <= 34'(r_r[k]);
                                r_t[k] <= '0;
                            end
                            r_fc    <= FC_ONE;
                            r_op    <= OP_PRD;
                            r_state <= ST_MUL;
                        end
                        FC_ONE: begin
                            // second frame: average with previous raw
                            for (int k = 0; k < 3; k++) begin
                                r_f[k] <= 34'(avg_sum[k] >>> 1);
                            end
                            r_fc    <= FC_RUN;
                            r_op    <= OP_TRD;
                            r_state <= ST_MUL;
                        end
                        default: begin
                            r_fc    <= FC_RUN;
                            r_state <= ST_JGO;
                        end
                    endcase
                end
                ST_JGO: r_state <= ST_JLEN;
                ST_JLEN: begin
                    if (vl_done) begin
                        r_len <= vl_len;
                        if (vl_len <= VL_LW'(r_rj)) begin
                            r_state <= ST_JDGO;
                        end else begin
                            // step too large for jitter removal: take raw
                            for (int k = 0; k < 3; k++) begin
                                r_f[k] <= 34'(r_r[k]);
                            end
                            r_op    <= OP_SMO;
                            r_k     <= 2'd0;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_JDGO: r_state <= ST_JDIV;
                ST_JDIV: begin
                    if (dv_done) begin
                        r_ratio <= dv_q;
                        r_op    <= OP_JIT;
                        r_k     <= 2'd0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: r_state <= ST_MWAIT;
                ST_MWAIT: begin
                    if (mul_done) begin
                        case (r_op)
                            OP_JIT:  r_f[r_k] <= 34'(acc_sum);
                            OP_SMO:  r_f[r_k] <= 34'(sat32(acc_sum));
                            OP_TRD:  r_t[r_k] <= sat32(acc_sum);
                            default: r_p[r_k] <= sat32(acc_sum);
                        endcase
                        if (r_k == 2'd2) begin
                            r_k <= 2'd0;
                            case (r_op)
                                OP_JIT: begin
                                    r_op    <= OP_SMO;
                                    r_state <= ST_MUL;
                                end
                                OP_SMO: begin
                                    r_op    <= OP_TRD;
                                    r_state <= ST_MUL;
                                end
                                OP_TRD: begin
                                    r_op    <= OP_PRD;
                                    r_state <= ST_MUL;
                                end
                                OP_PRD:  r_state <= ST_DGO;
                                default: r_state <= ST_WB;
                            endcase
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_DGO: r_state <= ST_DLEN;
                ST_DLEN: begin
                    if (vl_done) begin
                        r_len <= vl_len;
                        // pull the prediction back inside the deviation radius
                        if (vl_len > VL_LW'(r_rm)) begin
                            r_state <= ST_DDGO;
                        end else begin
                            r_state <= ST_WB;
                        end
                    end
                end
                ST_DDGO: r_state <= ST_DDIV;
                ST_DDIV: begin
                    if (dv_done) begin
                        r_ratio <= dv_q;
                        r_op    <= OP_DEV;
                        r_k     <= 2'd0;
                        r_state <= ST_MUL;
                    end
                end
                ST_WB: begin
                    // hold until the output register is free
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        o_out_index <= r_idx;
                        o_out_x     <= r_p[0];
                        o_out_y     <= r_p[1];
                        o_out_z     <= r_p[2];
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: verif/joint_double_exponential_filter_checker.sv
`timescale 1ns / 100ps
// Checker for the joint double exponential filter: predicts every filtered joint item
// and compares it with the block's output. Depends on jdef_pkg for widths and codes.
module joint_double_exponential_filter_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jdef_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jdef_pkg::CFG_DAT_W-1:0]    i_cfg_wdata,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [jdef_pkg::IDX_W-1:0]        i_joint_index,
    input  logic signed [jdef_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [jdef_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [jdef_pkg::POS_W-1:0] i_pos_z,
    input  logic                              i_inferred,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [jdef_pkg::IDX_W-1:0]        i_out_index,
    input  logic signed [jdef_pkg::POS_W-1:0] i_out_x,
    input  logic signed [jdef_pkg::POS_W-1:0] i_out_y,
    input  logic signed [jdef_pkg::POS_W-1:0] i_out_z,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_result_count
);
    import jdef_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] index;
        int               pos [3];
    } t_joint_out;

    t_joint_out expected_joints [$];

    logic [16:0] w_smooth, w_correct;
    logic [18:0] w_predict;
    logic [20:0] r_jitter, r_maxdev;

    int        st_raw   [NUM_JOINTS][3];
    int        st_filt  [NUM_JOINTS][3];
    int        st_trend [NUM_JOINTS][3];
    bit [1:0]  st_frame [NUM_JOINTS];

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned magn(longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    // floor(a * w / 2^16)
    function automatic longint wmul(longint a, longint unsigned w);
        longint unsigned p;
        p = magn(a) * w;
        if (a < 0) return -longint'((p + 65535) >> 16);
        return longint'(p >> 16);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned vec_length(longint a, longint b, longint c);
        longint unsigned ma, mb, mc, m;
        int s;
        ma = magn(a); mb = magn(b); mc = magn(c);
        m = ma;
        if (mb > m) m = mb;
        if (mc > m) m = mc;
        s = 0;
        while ((m >> s) >= 64'h8000_0000) s++;
        ma = ma >> s; mb = mb >> s; mc = mc >> s;
        return floor_sqrt(ma * ma + mb * mb + mc * mc) << s;
    endfunction

    // Advance one joint's state and return its predicted filtered position.
    function automatic t_joint_out smooth_joint(logic [IDX_W-1:0] j, int px, int py, int pz,
                                                logic inf);
        t_joint_out res;
        longint r[3], pf[3], pt[3], pr[3], f[3], t[3], p[3], d[3], s;
        longint unsigned ws, wc, rj, rm, len, ratio;
        bit [1:0] fc;
        ws = (w_smooth > WGT_ONE) ? 65536 : w_smooth;
        wc = (w_correct > WGT_ONE) ? 65536 : w_correct;
        rj = (r_jitter < JITTER_MIN) ? 7 : r_jitter;
        rm = r_maxdev;
        if (inf) begin
            rj = rj << 1;
            rm = rm << 1;
        end
        r[0] = px; r[1] = py; r[2] = pz;
        for (int k = 0; k < 3; k++) begin
            pf[k] = st_filt[j][k];
            pt[k] = st_trend[j][k];
            pr[k] = st_raw[j][k];
        end
        fc = st_frame[j];
        // an all-zero sample is invalid: restart the joint
        if (px == 0 && py == 0 && pz == 0) fc = 0;
        if (fc == 0) begin
            for (int k = 0; k < 3; k++) begin
                f[k] = r[k];
                t[k] = 0;
            end
            fc = 1;
        end else begin
            if (fc == 1) begin
                for (int k = 0; k < 3; k++) begin
                    s = r[k] + pr[k];
                    f[k] = (s < 0) ? -longint'((magn(s) + 1) >> 1) : (s >>> 1);
                end
                fc = 2;
            end else begin
                for (int k = 0; k < 3; k++) d[k] = r[k] - pf[k];
                len = vec_length(d[0], d[1], d[2]);
                if (len <= rj) begin
                    ratio = (len << 16) / rj;
                    for (int k = 0; k < 3; k++) f[k] = pf[k] + wmul(d[k], ratio);
                end else begin
                    for (int k = 0; k < 3; k++) f[k] = r[k];
                end
                for (int k = 0; k < 3; k++)
                    f[k] = sat_s32(f[k] + wmul((pf[k] + pt[k]) - f[k], ws));
                fc = 2;
            end
            for (int k = 0; k < 3; k++)
                t[k] = sat_s32(pt[k] + wmul((f[k] - pf[k]) - pt[k], wc));
        end
        for (int k = 0; k < 3; k++) p[k] = sat_s32(f[k] + wmul(t[k], w_predict));
        for (int k = 0; k < 3; k++) d[k] = p[k] - r[k];
        len = vec_length(d[0], d[1], d[2]);
        // pull the prediction back inside the deviation radius
        if (len > rm) begin
            ratio = (rm << 16) / len;
            for (int k = 0; k < 3; k++) p[k] = sat_s32(r[k] + wmul(d[k], ratio));
        end
        for (int k = 0; k < 3; k++) begin
            st_raw[j][k]   = int'(r[k]);
            st_filt[j][k]  = int'(f[k]);
            st_trend[j][k] = int'(t[k]);
            res.pos[k]     = int'(p[k]);
        end
        st_frame[j] = fc;
        res.index = j;
        return res;
    endfunction

    assign o_pending = expected_joints.size();

    always @(posedge i_clk) begin
        t_joint_out got, exp_j;
        if (!i_rst_n) begin
            w_smooth  = RST_SMOOTHING;
            w_correct = RST_CORRECTION;
            w_predict = RST_PREDICTION;
            r_jitter  = RST_JITTER;
            r_maxdev  = RST_MAXDEV;
            for (int j = 0; j < NUM_JOINTS; j++) begin
                st_frame[j] = 0;
                for (int k = 0; k < 3; k++) begin
                    st_raw[j][k] = 0;
                    st_filt[j][k] = 0;
                    st_trend[j][k] = 0;
                end
            end
            expected_joints.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SMOOTHING:  w_smooth  = i_cfg_wdata[16:0];
                    CFG_CORRECTION: w_correct = i_cfg_wdata[16:0];
                    CFG_PREDICTION: w_predict = i_cfg_wdata[18:0];
                    CFG_JITTER:     r_jitter  = i_cfg_wdata;
                    CFG_MAXDEV:     r_maxdev  = i_cfg_wdata;
                    default: ;
                endcase
            end
            // out-of-range joints are dropped by the block and predict nothing
            if (i_in_valid && !i_in_stall && i_joint_index < NUM_JOINTS)
                expected_joints.push_back(smooth_joint(i_joint_index, i_pos_x, i_pos_y,
                                                       i_pos_z, i_inferred));
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                got.index = i_out_index;
                got.pos[0] = i_out_x; got.pos[1] = i_out_y; got.pos[2] = i_out_z;
                if (expected_joints.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected item idx %0d (%0d %0d %0d)", $time,
                             got.index, got.pos[0], got.pos[1], got.pos[2]);
                end else begin
                    exp_j = expected_joints.pop_front();
                    if (exp_j.index != got.index) begin
                        o_fail_count++;
                        $display("%0t: index expected %0d actual %0d", $time,
                                 exp_j.index, got.index);
                    end
                    for (int k = 0; k < 3; k++) begin
                        if (exp_j.pos[k] != got.pos[k]) begin
                            o_fail_count++;
                            $display("%0t: joint %0d axis %0d expected %0d actual %0d",
                                     $time, exp_j.index, k, exp_j.pos[k], got.pos[k]);
                        end
                    end
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end
endmodule

FILE: verif/joint_double_exponential_filter_tb.sv
`timescale 1ns / 100ps
// Top of the joint double exponential filter testbench: clock, reset, stimulus and verdict.
// Depends on jdef_pkg, the block and joint_double_exponential_filter_checker.
module joint_double_exponential_filter_tb;
    import jdef_pkg::*;

    localparam int IDLE_LIMIT  = 8000;  // cycles without an accepted item, a taken result or a register write
    localparam int DRAIN_WAIT  = 250;   // beyond the slowest item latency
    localparam int ITEMS_PHASE = 225;

    logic                    i_clk, i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DAT_W-1:0]    i_cfg_wdata;
    logic                    i_in_valid, o_in_stall;
    logic [IDX_W-1:0]        i_joint_index;
    logic signed [POS_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic                    i_inferred;
    logic                    o_out_valid, i_out_stall;
    logic [IDX_W-1:0]        o_out_index;
    logic signed [POS_W-1:0] o_out_x, o_out_y, o_out_z;

    int fail_count, pending, result_count;
    int items_sent;
    int idle_pct;  // idle or stall chance in percent for the current phase
    bit send_gaps, recv_gaps, hold_req;
    int track [32][3];  // slow per-joint trajectories for well-formed sequences

    joint_double_exponential_filter DUT (.*);

    joint_double_exponential_filter_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .i_in_valid, .i_in_stall(o_in_stall), .i_joint_index, .i_pos_x, .i_pos_y,
        .i_pos_z, .i_inferred, .i_out_valid(o_out_valid), .i_out_stall,
        .i_out_index(o_out_index), .i_out_x(o_out_x), .i_out_y(o_out_y),
        .i_out_z(o_out_z), .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: random stalls per phase, plus a long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1;
            end else begin
                i_out_stall = recv_gaps ? ($urandom_range(99) < idle_pct) : 1'b0;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("** joint_double_exponential_filter: FAILED **");
                $finish;
            end
        end
    end

    // Offer one item and hold it until accepted.
    task automatic send_joint(logic [IDX_W-1:0] j, int x, int y, int z, logic inf);
        if (send_gaps) begin
            while ($urandom_range(99) < idle_pct) begin
                i_in_valid = 0;
                @(negedge i_clk);
            end
        end
        i_joint_index = j;
        i_pos_x = x; i_pos_y = y; i_pos_z = z;
        i_inferred = inf;
        i_in_valid = 1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic drain_block();
        i_in_valid = 0;
        while (pending != 0) @(negedge i_clk);
        // dropped items produce nothing, so give the block its full latency
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_all(logic [CFG_DAT_W-1:0] sm, logic [CFG_DAT_W-1:0] co,
                             logic [CFG_DAT_W-1:0] pr, logic [CFG_DAT_W-1:0] ji,
                             logic [CFG_DAT_W-1:0] md);
        write_reg(CFG_SMOOTHING, sm);
        write_reg(CFG_CORRECTION, co);
        write_reg(CFG_PREDICTION, pr);
        write_reg(CFG_JITTER, ji);
        write_reg(CFG_MAXDEV, md);
    endtask

    function automatic int wander(int sel);
        int sc;
        case (sel)
            0: sc = 16;
            1: sc = 600;
            2: sc = 4000;
            default: sc = 70000;
        endcase
        return int'($urandom_range(2 * sc)) - sc;
    endfunction

    // Mostly well-formed trajectories; the rest noise, restarts and extremes.
    task automatic send_random();
        logic [IDX_W-1:0] j;
        int kind, sel, p[3];
        j = ($urandom_range(99) < 4) ? IDX_W'($urandom_range(31, NUM_JOINTS))
                                     : IDX_W'($urandom_range(NUM_JOINTS - 1));
        kind = $urandom_range(99);
        sel = $urandom_range(3);
        for (int k = 0; k < 3; k++) begin
            if (kind < 75) begin
                track[j][k] = track[j][k] + wander(sel);
                p[k] = track[j][k];
            end else if (kind < 85) begin
                p[k] = $urandom;
            end else if (kind < 90) begin
                p[k] = 0;
            end else if (kind < 95) begin
                case ($urandom_range(3))
                    0: p[k] = 32'h7FFF_FFFF;
                    1: p[k] = 32'h8000_0000;
                    2: p[k] = -1;
                    default: p[k] = 1;
                endcase
            end else begin
                track[j][k] = $urandom;
                p[k] = track[j][k];
            end
        end
        send_joint(j, p[0], p[1], p[2], logic'($urandom_range(1)));
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_index = '0; i_cfg_wdata = '0;
        i_in_valid = 0; i_joint_index = '0;
        i_pos_x = 0; i_pos_y = 0; i_pos_z = 0; i_inferred = 0;
        send_gaps = 0; recv_gaps = 0; hold_req = 0;
        idle_pct = 78;
        items_sent = 0;
        for (int j = 0; j < 32; j++)
            for (int k = 0; k < 3; k++) track[j][k] = int'($urandom_range(200000)) - 100000;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: restart on zero, three frames on one joint, extremes, dropped index.
        send_joint(0, 0, 0, 0, 0);
        send_joint(1, 65536, 131072, -65536, 0);
        send_joint(1, 65600, 131000, -65500, 0);
        send_joint(1, 65700, 130900, -65400, 0);
        send_joint(1, 200000, 100000, -300000, 1);
        send_joint(1, 0, 0, 0, 0);
        send_joint(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_joint(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
        send_joint(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_joint(2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_joint(24, -1, -1, -1, 1);
        send_joint(24, -3, 5, -7, 1);
        send_joint(24, -2, 6, -8, 0);
        send_joint(25, 1000, 1000, 1000, 0);
        send_joint(31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send_joint(3, 0, 0, 1, 0);
        send_joint(3, 0, 1, 0, 0);
        send_joint(3, 1, 0, 0, 0);
        drain_block();

        // Phases: a register setting each, cycling through the idling modes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(CFG_DAT_W'(RST_SMOOTHING), CFG_DAT_W'(RST_CORRECTION),
                             CFG_DAT_W'(RST_PREDICTION), RST_JITTER, RST_MAXDEV);
                1: write_all('0, '0, '0, '0, '0);
                2: write_all(21'd65536, 21'd65536, 21'd262144, 21'd1048576, 21'd1048576);
                3: write_all(21'h1FFFF, 21'h1FFFF, 21'h7FFFF, 21'h1FFFFF, 21'h1FFFFF);
                4: write_all(21'd32768, 21'd49152, 21'd65536, 21'd6, 21'd1);
                default: write_all(CFG_DAT_W'($urandom_range(65536)),
                                   CFG_DAT_W'($urandom_range(65536)),
                                   CFG_DAT_W'($urandom_range(262144)),
                                   CFG_DAT_W'($urandom_range(8000)),
                                   CFG_DAT_W'($urandom_range(20000)));
            endcase
            send_gaps = (ph % 4 == 1) || (ph % 4 == 3);
            recv_gaps = (ph % 4 == 2) || (ph % 4 == 3);
            // both sides idling together use the lighter rate
            idle_pct = (send_gaps && recv_gaps) ? 37 : 78;
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                // hold the receiver off during the first phase so the block backs up
                if (ph == 0 && n == 40) hold_req = 1;
                send_random();
            end
            drain_block();
        end

        $display("Sent %0d joint items over 8 register settings and 4 idling modes;",
                 items_sent);
        $display("checked %0d filtered items.", result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("** joint_double_exponential_filter: PASSED **");
        end else begin
            $display("** joint_double_exponential_filter: FAILED **");
        end
        $finish;
    end
endmodule
